FILE: hw/rtl/lds_pkg.sv
// Shared constants, types and coefficient functions for the log-domain sRGB encoder.
`timescale 1ns / 1ps
package lds_pkg;

  localparam int RATIO_W = 32;
  localparam int LUM_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int CODE_W  = 16;
  localparam int LOG_W   = 22;  // signed Q.16 log2 of a ratio
  localparam int YT_W    = 38;  // signed Q.30 luminance term
  localparam int U_W     = 24;  // signed Q.16 exponent
  localparam int P_W     = 31;  // Q.30 fractional power of two

  localparam logic [GAIN_W-1:0]   SAT_RESET  = 16'd13107;
  localparam logic signed [21:0]  LOG2_10_X4 = 22'sd870824;
  localparam logic signed [U_W-1:0] U_THRESH = -24'sd545211;
  localparam logic [19:0]         C1292      = 20'd846725;
  localparam logic [19:0]         C1055      = 20'd69140;
  localparam logic signed [21:0]  C0055      = 22'sd3604;
  localparam logic signed [15:0]  INV24      = 16'sd27307;
  localparam logic [CODE_W-1:0]   CODE_MAX   = 16'hFFFF;

  // Register cycles of the log2 unit and of the whole datapath.
  localparam int LOG_LAT  = 17;
  localparam int PIPE_LAT = 40;

  typedef struct packed {
    logic low;   // linear segment of the curve
    logic sat;   // exponent non-negative, output pinned to full scale
  } lds_ctl_t;

  function automatic logic [31:0] isqrt64(input logic [63:0] x);
    logic [31:0] res;
    logic [31:0] trial;
    res = 32'd0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (32'd1 << b);
      if (({32'd0, trial} * {32'd0, trial}) <= x) begin
        res = trial;
      end
    end
    return res;
  endfunction

  // 2^(2^-j) in Q.30, each step the truncated root of the previous one.
  function automatic logic [P_W-1:0] pow2_coef(input int j);
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      if (k <= j) begin
        c = {32'd0, isqrt64(c << 30)};
      end
    end
    return c[P_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/log_domain_saturation_srgb_encode.sv
// Top level: config register, input stage, three channel pipelines and output skid.
// An accepted input word passes the input register, 40 datapath stages and the output
//   register on its way to the result word on the master side.
// Throughput: one pixel per cycle while the skid slot is empty; the rate is set by
//   the fully pipelined multipliers in the log2 squaring and power-of-two product chains.
// Reset: rst is synchronous, active high; it clears all valid bits and the skid slot
//   and loads saturation_gain with 13107 (0.8).
`timescale 1ns / 1ps
module log_domain_saturation_srgb_encode (
  input  logic         clk,
  input  logic         rst,
  // slave side: red_ratio [31:0], green_ratio [63:32], blue_ratio [95:64], log_lum [111:96]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,
  // master side: red_code [15:0], green_code [31:16], blue_code [47:32]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import lds_pkg::*;

  // ---------------- configuration ----------------
  logic [GAIN_W-1:0] sat_gain;

  assign pready = 1'b1;
  // a single register at byte address 0; anything at 4 and up reads zero
  assign prdata = paddr[2] ? 32'd0 : {16'd0, sat_gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_gain <= SAT_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      sat_gain <= pwdata[GAIN_W-1:0];
    end
  end

  // ---------------- pipeline control ----------------
  // The whole datapath advances while the skid slot is empty. A word leaving the
  // last stage goes to the output register, or into the skid slot when the
  // output register is still held by a stalled consumer.
  logic               ce;
  logic               sv;
  logic [47:0]        sd;
  logic               ovalid;
  logic [47:0]        odata;
  logic [PIPE_LAT:0]  vld;

  assign ce       = !sv;
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[PIPE_LAT-1:0], s_tvalid};
    end
  end

  // ---------------- input stage ----------------
  logic [RATIO_W-1:0]      r0, g0, b0;
  logic signed [LUM_W-1:0] ydl [LOG_LAT];
  logic signed [YT_W-1:0]  yterm;

  always_ff @(posedge clk) begin
    if (ce) begin
      r0     <= s_tdata[31:0];
      g0     <= s_tdata[63:32];
      b0     <= s_tdata[95:64];
      ydl[0] <= s_tdata[111:96];
      // line the luminance term up with the log2 results
      for (int i = 1; i < LOG_LAT; i++) begin
        ydl[i] <= ydl[i-1];
      end
      yterm  <= ydl[LOG_LAT-1] * LOG2_10_X4;
    end
  end

  // ---------------- channels ----------------
  logic [CODE_W-1:0] rc, gc, bc;

  lds_chan u_red (
    .clk (clk), .ce (ce), .sat_gain (sat_gain), .ratio (r0), .yterm (yterm), .code (rc)
  );
  lds_chan u_green (
    .clk (clk), .ce (ce), .sat_gain (sat_gain), .ratio (g0), .yterm (yterm), .code (gc)
  );
  lds_chan u_blue (
    .clk (clk), .ce (ce), .sat_gain (sat_gain), .ratio (b0), .yterm (yterm), .code (bc)
  );

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      sv     <= 1'b0;
    end else if (ce) begin
      if (vld[PIPE_LAT]) begin
        if (!ovalid || m_tready) begin
          ovalid <= 1'b1;
        end else begin
          sv <= 1'b1;
        end
      end else if (m_tready) begin
        ovalid <= 1'b0;
      end
    end else if (m_tready) begin
      // drain the skid slot; the output register stays full
      sv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (vld[PIPE_LAT]) begin
        if (!ovalid || m_tready) begin
          odata <= {bc, gc, rc};
        end else begin
          sd <= {bc, gc, rc};
        end
      end
    end else if (m_tready) begin
      odata <= sd;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = odata;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ovalid)
    else $error("skid slot full while output register empty");

  a_last_stage_lands: assert property (@(posedge clk) disable iff (rst)
    (ce && vld[PIPE_LAT]) |=> (ovalid && (sv || ce)))
    else $error("word from last stage lost");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && !paddr[2]) |=> (sat_gain == $past(pwdata[GAIN_W-1:0])))
    else $error("saturation gain write not taken");

  a_no_accept_on_skid: assert property (@(posedge clk) disable iff (rst)
    (sv && !m_tready) |=> sv)
    else $error("skid slot dropped without a transfer");
`endif
endmodule

FILE: hw/rtl/lds_log2.sv
// Pipelined log2 of a Q16.16 ratio by normalization and repeated squaring.
`timescale 1ns / 1ps
module lds_log2 (
  input  logic                                  clk,
  input  logic                                  ce,
  input  logic [lds_pkg::RATIO_W-1:0]           ratio,
  output logic signed [lds_pkg::LOG_W-1:0]      log_val
);
  import lds_pkg::*;

  logic [31:0] m_s  [17];
  logic [15:0] fr_s [17];
  logic [4:0]  n_s  [17];

  logic [31:0] r1;
  logic [4:0]  msb;

  // zero ratio counts as one LSB
  always_comb begin
    r1  = (ratio == '0) ? 32'd1 : ratio;
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (r1[i]) begin
        msb = i[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_s[0]  <= r1 << (5'd31 - msb);
      n_s[0]  <= msb;
      fr_s[0] <= 16'd0;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = {32'd0, m_s[k]} * {32'd0, m_s[k]};
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (ce) begin
        m_s[k+1]  <= t[32] ? t[32:1] : t[31:0];
        fr_s[k+1] <= {fr_s[k][14:0], t[32]};
        n_s[k+1]  <= n_s[k];
      end
    end
  end

  assign log_val = {({1'b0, n_s[16]} - 6'd16), fr_s[16]};
endmodule

FILE: hw/rtl/lds_pow2.sv
// Pipelined 2^x with scale, rounding, offset and clamp to a 16-bit code.
`timescale 1ns / 1ps
module lds_pow2 (
  input  logic                               clk,
  input  logic                               ce,
  input  logic signed [lds_pkg::U_W-1:0]     x,
  input  lds_pkg::lds_ctl_t                  ctl,
  output logic [lds_pkg::CODE_W-1:0]         code
);
  import lds_pkg::*;

  logic [P_W-1:0]    p_s   [17];
  logic [15:0]       f_s   [17];
  logic signed [7:0] ip_s  [17];
  lds_ctl_t          ctl_s [17];

  always_ff @(posedge clk) begin
    if (ce) begin
      p_s[0]   <= P_W'(1) << 30;
      f_s[0]   <= x[15:0];
      ip_s[0]  <= x[U_W-1:16];
      ctl_s[0] <= ctl;
    end
  end

  // one factor 2^(2^-j) per stage, picked by one fraction bit
  for (genvar k = 0; k < 16; k++) begin : g_mul
    localparam logic [P_W-1:0] CJ = pow2_coef(k + 1);
    logic [2*P_W-1:0] prod;
    assign prod = {{P_W{1'b0}}, p_s[k]} * {{P_W{1'b0}}, CJ};
    always_ff @(posedge clk) begin
      if (ce) begin
        p_s[k+1]   <= f_s[k][15-k] ? prod[P_W+29:30] : p_s[k];
        f_s[k+1]   <= f_s[k];
        ip_s[k+1]  <= ip_s[k];
        ctl_s[k+1] <= ctl_s[k];
      end
    end
  end

  logic [50:0]       sprod;
  logic signed [8:0] sh;
  lds_ctl_t          ctl_a;

  always_ff @(posedge clk) begin
    if (ce) begin
      sprod <= {20'd0, p_s[16]} * {31'd0, (ctl_s[16].low ? C1292 : C1055)};
      sh    <= 9'sd30 - {ip_s[16][7], ip_s[16]};
      ctl_a <= ctl_s[16];
    end
  end

  logic [63:0] rsum;
  logic [20:0] rnd;
  logic        big;
  lds_ctl_t    ctl_b;

  assign rsum = ({13'd0, sprod} + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      ctl_b <= ctl_a;
      if (sh > 9'sd62) begin
        rnd <= 21'd0;
        big <= 1'b0;
      end else if (sh <= 9'sd0) begin
        rnd <= 21'd0;
        big <= 1'b1;
      end else begin
        rnd <= rsum[20:0];
        big <= 1'b0;
      end
    end
  end

  logic signed [21:0] val;
  assign val = ctl_b.low ? $signed({1'b0, rnd}) : ($signed({1'b0, rnd}) - C0055);

  always_ff @(posedge clk) begin
    if (ce) begin
      if (ctl_b.sat || big || val > 22'sd65535) begin
        code <= CODE_MAX;
      end else if (val < 22'sd0) begin
        code <= '0;
      end else begin
        code <= val[CODE_W-1:0];
      end
    end
  end
endmodule

FILE: hw/rtl/lds_chan.sv
// One colour channel: log2, exponent in the log domain, segment select, power of two.
`timescale 1ns / 1ps
module lds_chan (
  input  logic                                clk,
  input  logic                                ce,
  input  logic [lds_pkg::GAIN_W-1:0]          sat_gain,
  input  logic [lds_pkg::RATIO_W-1:0]         ratio,
  input  logic signed [lds_pkg::YT_W-1:0]     yterm,
  output logic [lds_pkg::CODE_W-1:0]          code
);
  import lds_pkg::*;

  logic signed [LOG_W-1:0] log_val;

  lds_log2 u_log2 (
    .clk     (clk),
    .ce      (ce),
    .ratio   (ratio),
    .log_val (log_val)
  );

  logic signed [38:0]     sl;
  logic signed [YT_W-1:0] yt;
  logic signed [U_W-1:0]  u16;
  logic signed [38:0]     u30;
  logic signed [39:0]     pv;
  logic signed [U_W-1:0]  u16_d;
  lds_ctl_t               ctl;
  logic signed [U_W-1:0]  x;

  assign u30 = sl + {yt[YT_W-1], yt};

  always_ff @(posedge clk) begin
    if (ce) begin
      sl       <= $signed({1'b0, sat_gain}) * log_val;
      yt       <= yterm;
      u16      <= u30[37:14];
      pv       <= u16 * INV24;
      u16_d    <= u16;
      ctl.low  <= (u16 <= U_THRESH);
      ctl.sat  <= !u16[U_W-1];
    end
  end

  // upper segment works on the exponent divided by 2.4
  assign x = ctl.low ? u16_d : pv[39:16];

  lds_pow2 u_pow2 (
    .clk  (clk),
    .ce   (ce),
    .x    (x),
    .ctl  (ctl),
    .code (code)
  );
endmodule
